### sv/vmc_pkg.sv
// ----------------------------------------------------------------------------
// vmc_pkg: shared types, constants and the composition table
// Holds the word layout of the result path and the fixed (base, mark)
// to precomposed-letter table used by the mark composer.
// ----------------------------------------------------------------------------
`default_nettype none

package vmc_pkg;

  localparam int CP_W       = 21;
  localparam int TDATA_W    = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Combining marks
  localparam logic [CP_W-1:0] MARK_GRAVE      = 21'h000300;
  localparam logic [CP_W-1:0] MARK_ACUTE      = 21'h000301;
  localparam logic [CP_W-1:0] MARK_CIRCUMFLEX = 21'h000302;
  localparam logic [CP_W-1:0] MARK_TILDE      = 21'h000303;
  localparam logic [CP_W-1:0] MARK_BREVE      = 21'h000306;
  localparam logic [CP_W-1:0] MARK_HOOK       = 21'h000309;
  localparam logic [CP_W-1:0] MARK_HORN       = 21'h00031B;
  localparam logic [CP_W-1:0] MARK_DOT_BELOW  = 21'h000323;

  typedef struct packed {
    logic            last;
    logic [CP_W-1:0] point;
  } res_word_t;

  // Up to two result words written per step, word a first
  typedef struct packed {
    logic [1:0] cnt;
    res_word_t  a;
    res_word_t  b;
  } push_t;

  function automatic logic is_mark(input logic [CP_W-1:0] cp);
    return (cp == MARK_GRAVE)  || (cp == MARK_ACUTE) || (cp == MARK_CIRCUMFLEX) ||
           (cp == MARK_TILDE)  || (cp == MARK_BREVE) || (cp == MARK_HOOK) ||
           (cp == MARK_HORN)   || (cp == MARK_DOT_BELOW);
  endfunction

  // Look up {base, mark}; returns {hit, precomposed letter}
  function automatic logic [16:0] compose_lookup(input logic [31:0] key);
    logic [16:0] r;
    r = 17'd0;
    unique case (key)
      32'h00410300: r = {1'b1, 16'h00C0};  32'h00410301: r = {1'b1, 16'h00C1};
      32'h00410302: r = {1'b1, 16'h00C2};  32'h00410303: r = {1'b1, 16'h00C3};
      32'h00410306: r = {1'b1, 16'h0102};  32'h00410309: r = {1'b1, 16'h1EA2};
      32'h00410323: r = {1'b1, 16'h1EA0};
      32'h00450300: r = {1'b1, 16'h00C8};  32'h00450301: r = {1'b1, 16'h00C9};
      32'h00450302: r = {1'b1, 16'h00CA};  32'h00450303: r = {1'b1, 16'h1EBC};
      32'h00450309: r = {1'b1, 16'h1EBA};  32'h00450323: r = {1'b1, 16'h1EB8};
      32'h00490300: r = {1'b1, 16'h00CC};  32'h00490301: r = {1'b1, 16'h00CD};
      32'h00490303: r = {1'b1, 16'h0128};  32'h00490309: r = {1'b1, 16'h1EC8};
      32'h00490323: r = {1'b1, 16'h1ECA};
      32'h004F0300: r = {1'b1, 16'h00D2};  32'h004F0301: r = {1'b1, 16'h00D3};
      32'h004F0302: r = {1'b1, 16'h00D4};  32'h004F0303: r = {1'b1, 16'h00D5};
      32'h004F0309: r = {1'b1, 16'h1ECE};  32'h004F031B: r = {1'b1, 16'h01A0};
      32'h004F0323: r = {1'b1, 16'h1ECC};
      32'h00550300: r = {1'b1, 16'h00D9};  32'h00550301: r = {1'b1, 16'h00DA};
      32'h00550303: r = {1'b1, 16'h0168};  32'h00550309: r = {1'b1, 16'h1EE6};
      32'h0055031B: r = {1'b1, 16'h01AF};  32'h00550323: r = {1'b1, 16'h1EE4};
      32'h00590300: r = {1'b1, 16'h1EF2};  32'h00590301: r = {1'b1, 16'h00DD};
      32'h00590303: r = {1'b1, 16'h1EF8};  32'h00590309: r = {1'b1, 16'h1EF6};
      32'h00590323: r = {1'b1, 16'h1EF4};
      32'h00610300: r = {1'b1, 16'h00E0};  32'h00610301: r = {1'b1, 16'h00E1};
      32'h00610302: r = {1'b1, 16'h00E2};  32'h00610303: r = {1'b1, 16'h00E3};
      32'h00610306: r = {1'b1, 16'h0103};  32'h00610309: r = {1'b1, 16'h1EA3};
      32'h00610323: r = {1'b1, 16'h1EA1};
      32'h00650300: r = {1'b1, 16'h00E8};  32'h00650301: r = {1'b1, 16'h00E9};
      32'h00650302: r = {1'b1, 16'h00EA};  32'h00650303: r = {1'b1, 16'h1EBD};
      32'h00650309: r = {1'b1, 16'h1EBB};  32'h00650323: r = {1'b1, 16'h1EB9};
      32'h00690300: r = {1'b1, 16'h00EC};  32'h00690301: r = {1'b1, 16'h00ED};
      32'h00690303: r = {1'b1, 16'h0129};  32'h00690309: r = {1'b1, 16'h1EC9};
      32'h00690323: r = {1'b1, 16'h1ECB};
      32'h006F0300: r = {1'b1, 16'h00F2};  32'h006F0301: r = {1'b1, 16'h00F3};
      32'h006F0302: r = {1'b1, 16'h00F4};  32'h006F0303: r = {1'b1, 16'h00F5};
      32'h006F0309: r = {1'b1, 16'h1ECF};  32'h006F031B: r = {1'b1, 16'h01A1};
      32'h006F0323: r = {1'b1, 16'h1ECD};
      32'h00750300: r = {1'b1, 16'h00F9};  32'h00750301: r = {1'b1, 16'h00FA};
      32'h00750303: r = {1'b1, 16'h0169};  32'h00750309: r = {1'b1, 16'h1EE7};
      32'h0075031B: r = {1'b1, 16'h01B0};  32'h00750323: r = {1'b1, 16'h1EE5};
      32'h00790300: r = {1'b1, 16'h1EF3};  32'h00790301: r = {1'b1, 16'h00FD};
      32'h00790303: r = {1'b1, 16'h1EF9};  32'h00790309: r = {1'b1, 16'h1EF7};
      32'h00790323: r = {1'b1, 16'h1EF5};
      32'h00C20300: r = {1'b1, 16'h1EA6};  32'h00C20301: r = {1'b1, 16'h1EA4};
      32'h00C20303: r = {1'b1, 16'h1EAA};  32'h00C20309: r = {1'b1, 16'h1EA8};
      32'h00C20323: r = {1'b1, 16'h1EAC};
      32'h00CA0300: r = {1'b1, 16'h1EC0};  32'h00CA0301: r = {1'b1, 16'h1EBE};
      32'h00CA0303: r = {1'b1, 16'h1EC4};  32'h00CA0309: r = {1'b1, 16'h1EC2};
      32'h00CA0323: r = {1'b1, 16'h1EC6};
      32'h00D40300: r = {1'b1, 16'h1ED2};  32'h00D40301: r = {1'b1, 16'h1ED0};
      32'h00D40303: r = {1'b1, 16'h1ED6};  32'h00D40309: r = {1'b1, 16'h1ED4};
      32'h00D40323: r = {1'b1, 16'h1ED8};
      32'h00E20300: r = {1'b1, 16'h1EA7};  32'h00E20301: r = {1'b1, 16'h1EA5};
      32'h00E20303: r = {1'b1, 16'h1EAB};  32'h00E20309: r = {1'b1, 16'h1EA9};
      32'h00E20323: r = {1'b1, 16'h1EAD};
      32'h00EA0300: r = {1'b1, 16'h1EC1};  32'h00EA0301: r = {1'b1, 16'h1EBF};
      32'h00EA0303: r = {1'b1, 16'h1EC5};  32'h00EA0309: r = {1'b1, 16'h1EC3};
      32'h00EA0323: r = {1'b1, 16'h1EC7};
      32'h00F40300: r = {1'b1, 16'h1ED3};  32'h00F40301: r = {1'b1, 16'h1ED1};
      32'h00F40303: r = {1'b1, 16'h1ED7};  32'h00F40309: r = {1'b1, 16'h1ED5};
      32'h00F40323: r = {1'b1, 16'h1ED9};
      32'h01020300: r = {1'b1, 16'h1EB0};  32'h01020301: r = {1'b1, 16'h1EAE};
      32'h01020303: r = {1'b1, 16'h1EB4};  32'h01020309: r = {1'b1, 16'h1EB2};
      32'h01020323: r = {1'b1, 16'h1EB6};
      32'h01030300: r = {1'b1, 16'h1EB1};  32'h01030301: r = {1'b1, 16'h1EAF};
      32'h01030303: r = {1'b1, 16'h1EB5};  32'h01030309: r = {1'b1, 16'h1EB3};
      32'h01030323: r = {1'b1, 16'h1EB7};
      32'h01A00300: r = {1'b1, 16'h1EDC};  32'h01A00301: r = {1'b1, 16'h1EDA};
      32'h01A00303: r = {1'b1, 16'h1EE0};  32'h01A00309: r = {1'b1, 16'h1EDE};
      32'h01A00323: r = {1'b1, 16'h1EE2};
      32'h01A10300: r = {1'b1, 16'h1EDD};  32'h01A10301: r = {1'b1, 16'h1EDB};
      32'h01A10303: r = {1'b1, 16'h1EE1};  32'h01A10309: r = {1'b1, 16'h1EDF};
      32'h01A10323: r = {1'b1, 16'h1EE3};
      32'h01AF0300: r = {1'b1, 16'h1EEA};  32'h01AF0301: r = {1'b1, 16'h1EE8};
      32'h01AF0303: r = {1'b1, 16'h1EEE};  32'h01AF0309: r = {1'b1, 16'h1EEC};
      32'h01AF0323: r = {1'b1, 16'h1EF0};
      32'h01B00300: r = {1'b1, 16'h1EEB};  32'h01B00301: r = {1'b1, 16'h1EE9};
      32'h01B00303: r = {1'b1, 16'h1EEF};  32'h01B00309: r = {1'b1, 16'h1EED};
      32'h01B00323: r = {1'b1, 16'h1EF1};
      32'h1EA00302: r = {1'b1, 16'h1EAC};  32'h1EA00306: r = {1'b1, 16'h1EB6};
      32'h1EA10302: r = {1'b1, 16'h1EAD};  32'h1EA10306: r = {1'b1, 16'h1EB7};
      32'h1EB80302: r = {1'b1, 16'h1EC6};  32'h1EB90302: r = {1'b1, 16'h1EC7};
      32'h1ECC0302: r = {1'b1, 16'h1ED8};  32'h1ECD0302: r = {1'b1, 16'h1ED9};
      default:      r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/vmc_step.sv
// ----------------------------------------------------------------------------
// vmc_step: input register, held base and composition step
// Registers one accepted codepoint, then in one pass composes it with the
// held base and writes zero, one or two result words to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vmc_step (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [vmc_pkg::CP_W-1:0]  in_cp,
  input  wire logic                      in_last,
  input  wire logic                      space_ok,
  output vmc_pkg::push_t                 push
);

  logic                     stage_v_r, stage_v_nxt;
  logic [vmc_pkg::CP_W-1:0] stage_cp_r;
  logic                     stage_last_r;
  logic [vmc_pkg::CP_W-1:0] held_r, held_nxt;
  logic                     base_v_r, base_v_nxt;
  logic                     go;
  logic [16:0]              look;
  logic                     hit;
  logic [vmc_pkg::CP_W-1:0] nb;
  vmc_pkg::push_t           p;

  // Step fires when the queue can take two words
  assign go       = stage_v_r && space_ok;
  assign in_ready = !stage_v_r || go;

  assign look = vmc_pkg::compose_lookup({held_r[15:0], stage_cp_r[15:0]});
  assign hit  = base_v_r && (held_r[20:16] == 5'd0) && vmc_pkg::is_mark(stage_cp_r) &&
                look[16];

  // Compose, emit the displaced base, flush on end of text
  always_comb begin
    p          = '0;
    nb         = stage_cp_r;
    held_nxt   = held_r;
    base_v_nxt = base_v_r;
    if (!base_v_r) begin
      nb = stage_cp_r;
    end else if (hit) begin
      nb = {5'd0, look[15:0]};
    end else begin
      p.a.point = held_r;
      p.a.last  = 1'b0;
      p.cnt     = 2'd1;
      nb        = stage_cp_r;
    end
    if (stage_last_r) begin
      if (p.cnt == 2'd0) begin
        p.a.point = nb;
        p.a.last  = 1'b1;
      end else begin
        p.b.point = nb;
        p.b.last  = 1'b1;
      end
      p.cnt      = p.cnt + 2'd1;
      held_nxt   = '0;
      base_v_nxt = 1'b0;
    end else begin
      held_nxt   = nb;
      base_v_nxt = 1'b1;
    end
    if (!go) begin
      p.cnt      = 2'd0;
      held_nxt   = held_r;
      base_v_nxt = base_v_r;
    end
  end

  assign push = p;

  always_comb begin
    if (in_valid && in_ready) begin
      stage_v_nxt = 1'b1;
    end else if (go) begin
      stage_v_nxt = 1'b0;
    end else begin
      stage_v_nxt = stage_v_r;
    end
  end

  // Hold state and the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      held_r    <= '0;
      base_v_r  <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
      held_r    <= held_nxt;
      base_v_r  <= base_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_cp_r   <= in_cp;
      stage_last_r <= in_last;
    end
  end

endmodule

`default_nettype wire

### sv/vmc_out_fifo.sv
// ----------------------------------------------------------------------------
// vmc_out_fifo: result queue
// Takes up to two result words per cycle and presents one word per cycle
// to the output channel while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module vmc_out_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire vmc_pkg::push_t       push,
  output logic                      space_ok,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output vmc_pkg::res_word_t        out_word
);

  vmc_pkg::res_word_t              mem_r [vmc_pkg::FIFO_DEPTH];
  logic [vmc_pkg::PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [vmc_pkg::PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [vmc_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            pop;
  logic [vmc_pkg::PTR_W-1:0]       wr_ptr_b;

  assign out_valid = (cnt_r != '0);
  assign out_word  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign space_ok  = (cnt_r <= vmc_pkg::CNT_W'(vmc_pkg::FIFO_DEPTH - 2));
  assign wr_ptr_b  = wr_ptr_r + 1'b1;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + vmc_pkg::PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + vmc_pkg::PTR_W'(pop);
    cnt_nxt    = cnt_r + vmc_pkg::CNT_W'(push.cnt) - vmc_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write the words in order
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.a;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_b] <= push.b;
    end
  end

endmodule

`default_nettype wire

### sv/vietnamese_mark_composer.sv
// ----------------------------------------------------------------------------
// vietnamese_mark_composer: top level
// Recomposes base letters and Vietnamese combining marks into precomposed
// codepoints over a codepoint stream.
//
//   channel  | direction | word contents
//   ---------+-----------+-------------------------------------------
//   in_      | slave     | tdata: code_point; tlast: end_of_text
//   out_     | master     | tdata: out_point; tlast: out_last
//
// One codepoint is accepted per cycle unless the result queue backs up; each
// result passes the input register, then the result queue.
// The composition table match is one combinational pass. An end-of-text
// word that also pushes out a base yields two results; the four-word
// result queue then drains one word per cycle while out_tready is high.
// Output stalls back up to in_tready once fewer than two queue slots are
// free. Reset is synchronous and clears the held base and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vietnamese_mark_composer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [vmc_pkg::TDATA_W-1:0]  in_tdata,   // [20:0] code_point
  input  wire logic                         in_tlast,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [vmc_pkg::TDATA_W-1:0]       out_tdata,  // [20:0] out_point
  output logic                              out_tlast
);

  vmc_pkg::push_t     push;
  vmc_pkg::res_word_t word;
  logic               space_ok;

  vmc_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cp    (in_tdata[vmc_pkg::CP_W-1:0]),
    .in_last  (in_tlast),
    .space_ok (space_ok),
    .push     (push)
  );

  vmc_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (word)
  );

  // Pad the codepoint to whole bytes
  assign out_tdata = {{(vmc_pkg::TDATA_W - vmc_pkg::CP_W){1'b0}}, word.point};
  assign out_tlast = word.last;

endmodule

`default_nettype wire
